// ===== sv/bcvs_pkg.sv =====
// Shared types, constants and helper functions for the Bezier value and slope block.
package bcvs_pkg;

  // Number of control point registers and their width
  localparam int NUM_POINTS = 8;
  localparam int CP_W       = 32;
  localparam int CFG_IDX_W  = 3;

  // Phase and power format: unsigned Q1.16
  localparam int PW = 17;
  localparam logic [PW-1:0] ONE = 17'h10000;

  // Weighted basis: Q1.16 basis times an 8-bit integer weight
  localparam int WGT_W = 8;
  localparam int W_W   = PW + WGT_W;

  // Exact term sums (Q.32) and rounded results (Q15.16)
  localparam int ACC_W = 60;
  localparam int RES_W = 32;
  localparam logic signed [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic signed [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

  typedef logic [PW-1:0]                 pow_t;
  typedef pow_t [NUM_POINTS-1:0]         pow_vec_t;
  typedef logic signed [ACC_W-1:0]       acc_t;
  typedef acc_t [NUM_POINTS-1:0]         acc_vec_t;
  typedef logic signed [CP_W-1:0]        cp_t;
  typedef logic signed [RES_W-1:0]       res_t;

  // Q1.16 times Q1.16, rounded half up back to Q1.16
  function automatic pow_t q16_mul(pow_t a, pow_t b);
    logic [2*PW-1:0] p;
    p = {{PW{1'b0}}, a} * {{PW{1'b0}}, b} + (2*PW)'(32'h8000);
    return p[PW+15:16];
  endfunction

  // Binomial coefficient from Pascal's triangle, for elaboration only
  function automatic int binom(int n, int k);
    int row [NUM_POINTS];
    int i;
    int j;
    for (i = 0; i < NUM_POINTS; i++) row[i] = 0;
    row[0] = 1;
    for (i = 1; i <= n; i++) begin
      for (j = i; j >= 1; j--) begin
        row[j] = row[j] + row[j-1];
      end
    end
    return row[k];
  endfunction

endpackage

// ===== sv/bezier_curve_value_and_slope.sv =====
// Top level: Bezier curve value and slope over a phase, Bernstein form.
//
// Usage: drive in_phase (unsigned Q1.16, 65536 is one; larger values clamp to
// one) and pulse start. A beat is taken at every edge with start high and busy
// low; busy stays low, so a new phase may enter in every cycle.
// Each result shows on out_curve_value, out_curve_slope and out_saturated for
// exactly one cycle, flagged by out_valid. Results leave in the order beats
// came in. A beat passes through the input register, the power chain (one
// cell per power from 2 up to DEGREE), three stages in the term lanes (basis,
// weight, control point product) and four in the adder tree with rounding and
// clipping. Throughput is one beat per cycle. The receiver cannot stall the
// block and no result is held back.
// Control points are written through cfg_we/cfg_index/cfg_wdata, by the user
// only while no beat is in flight (not enforced by the block); points above
// DEGREE are kept but unused. Synchronous reset clears the control points to
// zero and drops every beat in flight.
module bezier_curve_value_and_slope #(
  parameter int DEGREE = 7
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [bcvs_pkg::PW-1:0]           in_phase,
  output logic                              out_valid,
  output bcvs_pkg::res_t                    out_curve_value,
  output bcvs_pkg::res_t                    out_curve_slope,
  output logic                              out_saturated,
  input  logic                              cfg_we,
  input  logic [bcvs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bcvs_pkg::CP_W-1:0]         cfg_wdata
);
  import bcvs_pkg::*;

  localparam int LAT = DEGREE + 7;

  cp_t      cp_r [NUM_POINTS];
  pow_t     s_c;
  pow_t     s0_r, t0_r;
  logic     v0_r;
  pow_vec_t sp_q [1:DEGREE];
  pow_vec_t tp_q [1:DEGREE];
  logic     vq   [1:DEGREE];
  acc_vec_t term_v, term_s;
  logic [2:0] vt_r;
  logic     vld_v, vld_s;
  logic     sat_v, sat_s;

  assign busy = 1'b0;

  // Control point registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_POINTS; i++) cp_r[i] <= '0;
    end else if (cfg_we) begin
      cp_r[cfg_index] <= cfg_wdata;
    end
  end

  // Input stage: clamp phase, form t = 1 - s
  assign s_c = (in_phase > ONE) ? ONE : in_phase;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s0_r <= s_c;
    t0_r <= ONE - s_c;
  end

  // Head of the power chain holds powers zero and one
  always_comb begin
    sp_q[1]    = '0;
    tp_q[1]    = '0;
    sp_q[1][0] = ONE;
    tp_q[1][0] = ONE;
    sp_q[1][1] = s0_r;
    tp_q[1][1] = t0_r;
  end
  assign vq[1] = v0_r;

  // Power chain, one cell per higher power
  for (genvar k = 2; k <= DEGREE; k++) begin : g_pow
    bcvs_pow_cell #(.K(k)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (vq[k-1]),
      .sp_in     (sp_q[k-1]),
      .tp_in     (tp_q[k-1]),
      .out_valid (vq[k]),
      .sp_out    (sp_q[k]),
      .tp_out    (tp_q[k])
    );
  end

  // Term lanes, unused lanes contribute zero
  for (genvar k = 0; k < NUM_POINTS; k++) begin : g_lane
    if (k < DEGREE) begin : g_mid
      bcvs_term_lane #(.DEGREE(DEGREE), .K(k)) u_lane (
        .clk    (clk),
        .sp     (sp_q[DEGREE]),
        .tp     (tp_q[DEGREE]),
        .cp_lo  (cp_r[k]),
        .cp_hi  (cp_r[k+1]),
        .term_v (term_v[k]),
        .term_s (term_s[k])
      );
    end else if (k == DEGREE) begin : g_last
      bcvs_term_lane #(.DEGREE(DEGREE), .K(k)) u_lane (
        .clk    (clk),
        .sp     (sp_q[DEGREE]),
        .tp     (tp_q[DEGREE]),
        .cp_lo  (cp_r[k]),
        .cp_hi  ('0),
        .term_v (term_v[k]),
        .term_s (term_s[k])
      );
    end else begin : g_off
      assign term_v[k] = '0;
      assign term_s[k] = '0;
    end
  end

  // Valid across the three lane stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vt_r <= '0;
    end else begin
      vt_r <= {vt_r[1:0], vq[DEGREE]};
    end
  end

  // Sums, rounding and clipping
  bcvs_sum u_sum_v (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vt_r[2]),
    .terms     (term_v),
    .out_valid (vld_v),
    .result    (out_curve_value),
    .sat       (sat_v)
  );

  bcvs_sum u_sum_s (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vt_r[2]),
    .terms     (term_s),
    .out_valid (vld_s),
    .result    (out_curve_slope),
    .sat       (sat_s)
  );

  assign out_valid     = vld_v;
  assign out_saturated = sat_v | sat_s;

  // Every result comes from an earlier start beat
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT))
    else $error("result without a matching start beat");

  // Value and slope paths stay in step
  a_paths_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    vld_v == vld_s)
    else $error("value and slope paths out of step");

endmodule

// ===== sv/bcvs_pow_cell.sv =====
// One cell of the power chain: adds s^K and t^K to the vectors it passes on.
module bcvs_pow_cell #(
  parameter int K = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  bcvs_pkg::pow_vec_t sp_in,
  input  bcvs_pkg::pow_vec_t tp_in,
  output logic               out_valid,
  output bcvs_pkg::pow_vec_t sp_out,
  output bcvs_pkg::pow_vec_t tp_out
);
  import bcvs_pkg::*;

  logic     valid_r;
  pow_vec_t sp_r, sp_nxt;
  pow_vec_t tp_r, tp_nxt;

  // Next power from the previous one; entry 1 holds s and t themselves
  always_comb begin
    sp_nxt    = sp_in;
    tp_nxt    = tp_in;
    sp_nxt[K] = q16_mul(sp_in[K-1], sp_in[1]);
    tp_nxt[K] = q16_mul(tp_in[K-1], tp_in[1]);
  end

  // Beat valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    sp_r <= sp_nxt;
    tp_r <= tp_nxt;
  end

  assign out_valid = valid_r;
  assign sp_out    = sp_r;
  assign tp_out    = tp_r;

  // Powers never grow along the chain
  a_pow_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (sp_r[K] <= sp_r[K-1]) && (tp_r[K] <= tp_r[K-1]))
    else $error("power grew along the chain");

  // s and t travel intact and still add up to one
  a_st_sum: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (PW+1)'(sp_r[1]) + (PW+1)'(tp_r[1]) == (PW+1)'(ONE))
    else $error("s and t lost in the chain");

endmodule

// ===== sv/bcvs_term_lane.sv =====
// One term lane: Bernstein basis, binomial weight and control point products.
module bcvs_term_lane #(
  parameter int DEGREE = 7,
  parameter int K      = 0
) (
  input  logic               clk,
  input  bcvs_pkg::pow_vec_t sp,
  input  bcvs_pkg::pow_vec_t tp,
  input  bcvs_pkg::cp_t      cp_lo,
  input  bcvs_pkg::cp_t      cp_hi,
  output bcvs_pkg::acc_t     term_v,
  output bcvs_pkg::acc_t     term_s
);
  import bcvs_pkg::*;

  // Weights C(M,k) for the value, M*C(M-1,k) for the slope
  localparam logic [WGT_W-1:0] CV = WGT_W'(binom(DEGREE, K));
  localparam logic [WGT_W-1:0] CS =
    (K < DEGREE) ? WGT_W'(DEGREE * binom(DEGREE - 1, K)) : '0;
  localparam int JS = (K < DEGREE) ? DEGREE - 1 - K : 0;

  pow_t                   bv_r, bs_r;
  logic [W_W-1:0]         wv_r, ws_r;
  logic signed [CP_W:0]   df_r;
  acc_t                   tv_r, ts_r;
  logic signed [CP_W+W_W:0]   pv;
  logic signed [CP_W+W_W+1:0] ps;

  // Stage A: basis products s^k * t^(M-k) and s^k * t^(M-1-k)
  always_ff @(posedge clk) begin
    bv_r <= q16_mul(sp[K], tp[DEGREE-K]);
    bs_r <= q16_mul(sp[K], tp[JS]);
  end

  // Stage B: integer weights and control point difference
  always_ff @(posedge clk) begin
    wv_r <= {{WGT_W{1'b0}}, bv_r} * {{PW{1'b0}}, CV};
    ws_r <= {{WGT_W{1'b0}}, bs_r} * {{PW{1'b0}}, CS};
    df_r <= (CP_W+1)'(cp_hi) - (CP_W+1)'(cp_lo);
  end

  // Stage C: control point times weighted basis
  always_comb begin
    pv = $signed(cp_lo) * $signed({1'b0, wv_r});
    ps = df_r * $signed({1'b0, ws_r});
  end

  always_ff @(posedge clk) begin
    tv_r <= ACC_W'(pv);
    ts_r <= ACC_W'(ps);
  end

  assign term_v = tv_r;
  assign term_s = ts_r;

endmodule

// ===== sv/bcvs_sum.sv =====
// Registered adder tree over the terms, then round to Q15.16 and saturate.
module bcvs_sum (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  bcvs_pkg::acc_vec_t terms,
  output logic               out_valid,
  output bcvs_pkg::res_t     result,
  output logic               sat
);
  import bcvs_pkg::*;

  logic [3:0] vld_r;
  acc_t       l1_r [4];
  acc_t       l2_r [2];
  acc_t       l3_r;
  acc_t       rnd;
  logic       fits;
  res_t       res_r, res_nxt;
  logic       sat_r, sat_nxt;

  // Valid follows the four stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], in_valid};
    end
  end

  // Three adder levels
  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      l1_r[i] <= $signed(terms[2*i]) + $signed(terms[2*i+1]);
    end
    for (int i = 0; i < 2; i++) begin
      l2_r[i] <= l1_r[2*i] + l1_r[2*i+1];
    end
    l3_r <= l2_r[0] + l2_r[1];
  end

  // Round half up, then clip to 32 bits
  always_comb begin
    rnd  = (l3_r + ACC_W'(32'sh8000)) >>> 16;
    fits = (&rnd[ACC_W-1:RES_W-1]) | ~(|rnd[ACC_W-1:RES_W-1]);
    if (fits) begin
      res_nxt = rnd[RES_W-1:0];
      sat_nxt = 1'b0;
    end else begin
      res_nxt = rnd[ACC_W-1] ? RES_MIN : RES_MAX;
      sat_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    sat_r <= sat_nxt;
  end

  assign out_valid = vld_r[3];
  assign result    = res_r;
  assign sat       = sat_r;

  // A clipped result sits on a rail
  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[3] && sat_r) |-> (res_r == RES_MAX || res_r == RES_MIN))
    else $error("saturation flag without a rail value");

endmodule
